// ===== rtl/core/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared constants, codes and command/status types for the page frame
// allocator core.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // sizing
    localparam int PAGE_BYTES  = 4096;
    localparam int STACK_DEPTH = 1024;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // field widths
    localparam int ADDR_W = 32;
    localparam int FC_W   = 21;
    localparam int STS_W  = 3;
    localparam int USED_W = ADDR_W - PAGE_SHIFT;
    localparam int CMP_W  = (USED_W > FC_W) ? USED_W : FC_W;

    // config port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = CFG_IDX_W'(1);

    localparam logic [ADDR_W-1:0] UMS_RESET   = ADDR_W'(16777216);
    localparam logic [FC_W-1:0]   TOTAL_RESET = FC_W'(32768);

    typedef enum logic [STS_W-1:0] {
        STS_OK           = 3'd0,
        STS_OUT_OF_FRAMES = 3'd1,
        STS_MISALIGNED   = 3'd2,
        STS_OUT_OF_RANGE = 3'd3,
        STS_STACK_FULL   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the incoming word
        logic exec;      // decide, update pointers, touch the stack
        logic load_out;  // move the result into the output register
        logic cfg_wr;    // config register write
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // output register empty or being taken
    } t_dp_sts;

endpackage

// ===== rtl/core/pfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfa_ctrl
// Sequencer: accept, execute, finish. Issues commands to the datapath.
// ----------------------------------------------------------------------------
module pfa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  pfa_pkg::t_dp_sts i_sts,
    output pfa_pkg::t_dp_cmd o_cmd
);
    import pfa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cfg_ready = 1'b1;
                o_cmd.cfg_wr = i_cfg_valid;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_FIN;
            end
            ST_FIN: begin
                // next word may enter as this result leaves
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_in_stall     = 1'b0;
                    if (i_in_valid) begin
                        o_cmd.capture = 1'b1;
                        n_state       = ST_EXEC;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/pfa_dpath.sv =====
// ----------------------------------------------------------------------------
// pfa_dpath
// Pool registers, free stack memory, decision logic and output register.
// ----------------------------------------------------------------------------
module pfa_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pfa_pkg::t_dp_cmd                   i_cmd,
    output pfa_pkg::t_dp_sts                   o_sts,
    input  logic                               i_mode,
    input  logic [pfa_pkg::ADDR_W-1:0]         i_frame_address,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pfa_pkg::ADDR_W-1:0]         i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pfa_pkg::ADDR_W-1:0]         o_given_address,
    output logic [pfa_pkg::STS_W-1:0]          o_status,
    output logic [pfa_pkg::FC_W-1:0]           o_free_count
);
    import pfa_pkg::*;

    // config and pool state
    logic [ADDR_W-1:0] r_pool_base;
    logic [FC_W-1:0]   r_total_frames;
    logic [ADDR_W-1:0] r_next_unclaimed;
    logic [CNT_W-1:0]  r_stack_count;

    // free stack
    logic [ADDR_W-1:0] r_stack_mem [STACK_DEPTH];
    logic [ADDR_W-1:0] r_rd_data;

    // captured word and pending result
    logic              r_mode;
    logic [ADDR_W-1:0] r_faddr;
    t_status           r_res_status;
    logic              r_res_pop;
    logic [ADDR_W-1:0] r_res_addr;

    // output register
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    t_status           r_out_status;
    logic [FC_W-1:0]   r_out_fc;

    // decision
    logic [CMP_W-1:0]  used;
    logic [CMP_W-1:0]  tot_ext;
    logic              have_unclaimed;
    logic [ADDR_W:0]   bump_sum;
    logic              bump_fits;
    logic              stk_empty;
    logic              stk_full;
    logic [CNT_W-1:0]  cnt_dec;
    logic [STK_AW-1:0] rd_idx;
    logic              dec_pop;
    logic              dec_push;
    logic              dec_bump;
    t_status           dec_status;
    logic [FC_W-1:0]   unclaimed;
    logic [FC_W:0]     fc_sum;
    logic [FC_W-1:0]   free_cnt;

    always_comb begin
        used           = CMP_W'(r_next_unclaimed >> PAGE_SHIFT);
        tot_ext        = CMP_W'(r_total_frames);
        have_unclaimed = tot_ext > used;
        bump_sum       = {1'b0, r_next_unclaimed} + (ADDR_W+1)'(PAGE_BYTES);
        // pointer may land exactly on 2^32, not past it
        bump_fits      = !bump_sum[ADDR_W] || (bump_sum[ADDR_W-1:0] == '0);
        stk_empty      = r_stack_count == '0;
        stk_full       = r_stack_count >= CNT_W'(STACK_DEPTH);
        cnt_dec        = r_stack_count - CNT_W'(1);
        rd_idx         = cnt_dec[STK_AW-1:0];

        dec_pop    = 1'b0;
        dec_push   = 1'b0;
        dec_bump   = 1'b0;
        dec_status = STS_OK;
        if (!r_mode) begin
            if (!stk_empty) begin
                dec_pop = 1'b1;
            end else if (have_unclaimed && bump_fits) begin
                dec_bump = 1'b1;
            end else begin
                dec_status = STS_OUT_OF_FRAMES;
            end
        end else begin
            if (r_faddr[PAGE_SHIFT-1:0] != '0) begin
                dec_status = STS_MISALIGNED;
            end else if (!((r_pool_base < r_faddr) && (r_faddr < r_next_unclaimed))) begin
                dec_status = STS_OUT_OF_RANGE;
            end else if (stk_full) begin
                dec_status = STS_STACK_FULL;
            end else begin
                dec_push = 1'b1;
            end
        end

        // free count from the already-updated pool state
        unclaimed = have_unclaimed ? FC_W'(tot_ext - used) : '0;
        fc_sum    = {1'b0, unclaimed} + (FC_W+1)'(r_stack_count);
        free_cnt  = fc_sum[FC_W] ? '1 : fc_sum[FC_W-1:0];

        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base      <= UMS_RESET;
            r_total_frames   <= TOTAL_RESET;
            r_next_unclaimed <= UMS_RESET + ADDR_W'(PAGE_BYTES);
            r_stack_count    <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cmd.cfg_wr) begin
                case (i_cfg_index)
                    CFG_POOL_BASE: begin
                        r_pool_base      <= i_cfg_data;
                        r_next_unclaimed <= i_cfg_data + ADDR_W'(PAGE_BYTES);
                        r_stack_count    <= '0;
                    end
                    CFG_TOTAL_FRAMES: begin
                        r_total_frames <= i_cfg_data[FC_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.exec) begin
                if (dec_pop) begin
                    r_stack_count <= cnt_dec;
                end else if (dec_push) begin
                    r_stack_count <= r_stack_count + CNT_W'(1);
                end
                if (dec_bump) begin
                    r_next_unclaimed <= bump_sum[ADDR_W-1:0];
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stack memory, one port each way
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && dec_push) begin
            r_stack_mem[r_stack_count[STK_AW-1:0]] <= r_faddr;
        end
        if (i_cmd.exec && dec_pop) begin
            r_rd_data <= r_stack_mem[rd_idx];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_faddr <= i_frame_address;
        end
        if (i_cmd.exec) begin
            r_res_status <= dec_status;
            r_res_pop    <= dec_pop;
            r_res_addr   <= dec_bump ? r_next_unclaimed : '0;
        end
        if (i_cmd.load_out) begin
            r_out_addr   <= r_res_pop ? r_rd_data : r_res_addr;
            r_out_status <= r_res_status;
            r_out_fc     <= free_cnt;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_given_address = r_out_addr;
    assign o_status        = r_out_status;
    assign o_free_count    = r_out_fc;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stack_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_load_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten");

    a_pop_dec : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && dec_pop) |=> (r_stack_count == $past(cnt_dec)))
        else $error("pop did not drop the count");

    a_push_inc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && dec_push) |=> (r_stack_count == $past(r_stack_count) + CNT_W'(1)))
        else $error("push did not raise the count");

endmodule

// ===== rtl/core/page_frame_allocator_core.sv =====
// Flow: an accepted word is captured, EXEC decides it and FIN loads the
//   output register once it is free (a stalled output holds FIN).
// A new word is taken only in IDLE, or in FIN as the last result leaves; the
//   free stack's registered read port sets the execute/finish pair.
// Reset: synchronous, active low. Config registers return to their reset
//   values, the bump pointer to user start plus one page, stack emptied.
// ----------------------------------------------------------------------------
// page_frame_allocator_core
// Hands out physical page frames: pops the free stack first, otherwise bumps
// a pointer through never-used memory. Frees are checked for alignment and
// range, then pushed on the stack. Every result carries the free frame count.
// ----------------------------------------------------------------------------
module page_frame_allocator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [pfa_pkg::ADDR_W-1:0]    i_frame_address,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pfa_pkg::ADDR_W-1:0]    o_given_address,
    output logic [pfa_pkg::STS_W-1:0]     o_status,
    output logic [pfa_pkg::FC_W-1:0]      o_free_count,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pfa_pkg::ADDR_W-1:0]    i_cfg_data
);
    import pfa_pkg::*;

    // Controller and datapath talk only through these two bundles.
    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer: IDLE takes a word (and config writes); EXEC decides the
    // operation, moves the pointers and issues the stack read or write;
    // FIN waits for the output register and may take the next word in the
    // same cycle, so back-to-back words run EXEC/FIN/EXEC/FIN.
    pfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: pool registers, free stack memory (registered read), and
    // the output register which decouples the result from the request side.
    pfa_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_mode),
        .i_frame_address (i_frame_address),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_given_address (o_given_address),
        .o_status        (o_status),
        .o_free_count    (o_free_count)
    );

endmodule

// ===== sim/page_frame_allocator_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_frame_allocator_core_test
// Self-checking bench for the page frame allocator core. A queue-fed driver
// offers request words in bursts and gaps. A monitor compares every result
// word against a cycle-free predictor of the bump pointer, the free stack and
// the free frame count. Config registers are rewritten between phases.
// ----------------------------------------------------------------------------
module page_frame_allocator_core_test;

    import pfa_pkg::*;

    // request opcodes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // indexes with no register behind them; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    localparam logic [FC_W-1:0]   FC_MAX    = {FC_W{1'b1}};
    localparam logic [ADDR_W-1:0] ALL_ONES  = {ADDR_W{1'b1}};
    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] frame_address;
    } t_frame_request;

    typedef struct packed {
        logic [ADDR_W-1:0] given_address;
        t_status           status;
        logic [FC_W-1:0]   free_count;
    } t_frame_result;

    // DUT connections; everything driven here starts at a known value
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 i_mode          = MODE_ALLOC;
    logic [ADDR_W-1:0]    i_frame_address = '0;
    logic                 i_out_stall     = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = CFG_POOL_BASE;
    logic [ADDR_W-1:0]    i_cfg_data      = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [ADDR_W-1:0]    o_given_address;
    logic [STS_W-1:0]     o_status;
    logic [FC_W-1:0]      o_free_count;
    logic                 o_cfg_ready;

    page_frame_allocator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (i_mode),
        .i_frame_address (i_frame_address),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_given_address (o_given_address),
        .o_status        (o_status),
        .o_free_count    (o_free_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: shadow of the allocator after every accepted word
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] pool_base      = UMS_RESET;
    logic [FC_W-1:0]   total_frames   = TOTAL_RESET;
    logic [ADDR_W-1:0] next_unclaimed = UMS_RESET + ADDR_W'(PAGE_BYTES);
    logic [ADDR_W-1:0] frame_stack [STACK_DEPTH];
    int                stack_fill     = 0;

    t_frame_request pending_requests[$];
    t_frame_result  due_results[$];
    int             errors = 0;

    // never-used frames left below the machine's frame count
    function automatic longint unsigned unclaimed_frames();
        longint unsigned used;
        longint unsigned limit;
        used  = longint'(next_unclaimed >> PAGE_SHIFT);
        limit = longint'(total_frames);
        return (limit > used) ? limit - used : 0;
    endfunction

    function automatic logic [FC_W-1:0] free_frame_count();
        longint unsigned avail;
        avail = unclaimed_frames() + longint'(stack_fill);
        return (avail > longint'(FC_MAX)) ? FC_MAX : FC_W'(avail);
    endfunction

    // one request word in, one result word out; updates the shadow state
    function automatic t_frame_result serve_request(t_frame_request req);
        t_frame_result res;
        logic [ADDR_W-1:0] a;
        a = req.frame_address;
        res.given_address = '0;
        res.status        = STS_OK;
        if (req.mode == MODE_ALLOC) begin
            if (stack_fill > 0) begin
                stack_fill--;
                res.given_address = frame_stack[stack_fill];
            end else if (unclaimed_frames() > 0 &&
                         longint'(next_unclaimed) + PAGE_BYTES <= 64'h1_0000_0000) begin
                res.given_address = next_unclaimed;
                next_unclaimed    = next_unclaimed + ADDR_W'(PAGE_BYTES);
            end else begin
                res.status = STS_OUT_OF_FRAMES;
            end
        end else begin
            // alignment is judged before range
            if (a[PAGE_SHIFT-1:0] != '0)
                res.status = STS_MISALIGNED;
            else if (!(pool_base < a && a < next_unclaimed))
                res.status = STS_OUT_OF_RANGE;
            else if (stack_fill >= STACK_DEPTH)
                res.status = STS_STACK_FULL;
            else begin
                frame_stack[stack_fill] = a;
                stack_fill++;
            end
        end
        res.free_count = free_frame_count();
        return res;
    endfunction

    function automatic void apply_register_write(logic [CFG_IDX_W-1:0] idx,
                                                 logic [ADDR_W-1:0] data);
        case (idx)
            CFG_POOL_BASE: begin
                // new start reloads the whole pool
                pool_base      = data;
                next_unclaimed = data + ADDR_W'(PAGE_BYTES);
                stack_fill     = 0;
            end
            CFG_TOTAL_FRAMES: begin
                total_frames = data[FC_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    int cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: pops the pending queue, bursts and gaps at random. A word
    // held under stall keeps its payload; prediction happens on accept.
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        t_frame_request req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                req.mode          = i_mode;
                req.frame_address = i_frame_address;
                due_results.push_back(serve_request(req));
            end
            if (i_in_valid && o_in_stall) begin
                // held: nothing changes
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                req = pending_requests.pop_front();
                i_in_valid      <= 1'b1;
                i_mode          <= req.mode;
                i_frame_address <= req.frame_address;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // mostly short bursts, now and then a long unbroken run
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                             : $urandom_range(0, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side stall: changing styles plus a long hold every so often
    // so the core backs up and stalls its request side.
    // ------------------------------------------------------------------
    int results_taken = 0;
    int next_hold_at  = 150;
    int hold_left     = 0;
    int style         = 0;
    int style_left    = 0;
    int stall_phase   = 0;

    always @(posedge i_clk) begin
        logic stall_next;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                results_taken++;
            if (hold_left == 0 && results_taken >= next_hold_at) begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + 800;
            end
            if (style_left == 0) begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(32, 200);
            end else begin
                style_left--;
            end
            stall_phase++;
            case (style)
                0:       stall_next = 1'b0;
                1:       stall_next = ($urandom_range(0, 9) < 3);
                2:       stall_next = ($urandom_range(0, 9) < 7);
                default: stall_next = stall_phase[1];
            endcase
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end
            i_out_stall <= stall_next;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every accepted result word against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [ADDR_W-1:0] want,
                                        logic [ADDR_W-1:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_frame_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: result word with nothing expected, expected none, got %0h/%0d/%0d",
                         $time, o_given_address, o_status, o_free_count);
            end else begin
                want = due_results.pop_front();
                check_field("given_address", want.given_address, o_given_address);
                check_field("status", ADDR_W'(want.status), ADDR_W'(o_status));
                check_field("free_count", ADDR_W'(want.free_count), ADDR_W'(o_free_count));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------
    task automatic send_request(logic mode, logic [ADDR_W-1:0] a);
        t_frame_request req;
        req.mode          = mode;
        req.frame_address = a;
        pending_requests.push_back(req);
    endtask

    // block idle: queue empty, nothing offered, nothing outstanding
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || due_results.size() != 0);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        apply_register_write(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    // random mix around a base: allocs, likely-good frees, misaligned,
    // wild addresses and the start frame itself
    task automatic queue_mixed(int count, logic [ADDR_W-1:0] base);
        int pick;
        logic [ADDR_W-1:0] a;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            a    = base + ($urandom_range(1, 48) << PAGE_SHIFT);
            if (pick < 45)
                send_request(MODE_ALLOC, $urandom);
            else if (pick < 75)
                send_request(MODE_FREE, a);
            else if (pick < 85)
                send_request(MODE_FREE, a + $urandom_range(1, PAGE_BYTES - 1));
            else if (pick < 95)
                send_request(MODE_FREE, $urandom);
            else
                send_request(MODE_FREE, base);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [ADDR_W-1:0] start;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        // reset pool: bump, double free, pops, alignment and range edges
        send_request(MODE_ALLOC, ALL_ONES);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 32'h0100_1000);
        send_request(MODE_FREE, 32'h0100_1000);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 32'h0100_1001);
        send_request(MODE_FREE, 32'h0100_0000);   // start frame itself
        send_request(MODE_FREE, 32'h0100_3000);   // at the bump pointer
        send_request(MODE_FREE, 32'h0000_0800);   // misaligned and below
        send_request(MODE_FREE, 32'hFFFF_F000);
        send_request(MODE_FREE, ALL_ONES);
        wait_quiet();

        // spare indexes do nothing; then a tiny pool that runs dry
        write_register(CFG_SPARE_LO, ALL_ONES);
        write_register(CFG_SPARE_HI, 32'h0000_2000);
        write_register(CFG_TOTAL_FRAMES, 32'd5);
        write_register(CFG_POOL_BASE, 32'h0000_2000);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_FREE, 32'h0000_3000);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        wait_quiet();
        write_register(CFG_TOTAL_FRAMES, 32'd0);
        send_request(MODE_ALLOC, '0);
        wait_quiet();

        // top of address space: unaligned start where the next page would
        // carry past 2^32, then an aligned one that wraps the pointer
        write_register(CFG_TOTAL_FRAMES, 32'd1048576);
        write_register(CFG_POOL_BASE, 32'hFFFF_E800);
        send_request(MODE_ALLOC, '0);
        wait_quiet();
        write_register(CFG_POOL_BASE, 32'hFFFF_E000);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        wait_quiet();

        // count saturation: huge frame count plus repeated frees
        write_register(CFG_TOTAL_FRAMES, ALL_ONES);
        write_register(CFG_POOL_BASE, '0);
        send_request(MODE_ALLOC, '0);
        repeat (3) send_request(MODE_FREE, 32'h0000_1000);
        wait_quiet();

        // random phases
        write_register(CFG_TOTAL_FRAMES, TOTAL_RESET);
        write_register(CFG_POOL_BASE, UMS_RESET);
        queue_mixed(80, UMS_RESET);
        wait_quiet();

        write_register(CFG_POOL_BASE, 32'h0000_2000);
        write_register(CFG_TOTAL_FRAMES, 32'd24);
        queue_mixed(80, 32'h0000_2000);
        wait_quiet();

        start = ADDR_W'($urandom_range(0, 32'h000F_FF00)) << PAGE_SHIFT;
        write_register(CFG_POOL_BASE, start);
        write_register(CFG_TOTAL_FRAMES, (start >> PAGE_SHIFT) + $urandom_range(0, 80));
        queue_mixed(60, start);
        wait_quiet();

        // unaligned start address
        write_register(CFG_POOL_BASE, 32'h0040_0800);
        write_register(CFG_TOTAL_FRAMES, 32'd1064);
        queue_mixed(50, 32'h0040_0000);
        wait_quiet();

        // load the free stack deep with repeated frees, then mix on top
        write_register(CFG_POOL_BASE, '0);
        write_register(CFG_TOTAL_FRAMES, ALL_ONES);
        send_request(MODE_ALLOC, '0);
        send_request(MODE_ALLOC, '0);
        for (int n = 0; n < 300; n++) begin
            if ($urandom_range(0, 99) < 95)
                send_request(MODE_FREE, $urandom_range(0, 1) ? 32'h0000_1000 : 32'h0000_2000);
            else
                send_request(MODE_FREE, $urandom);
        end
        queue_mixed(50, '0);
        wait_quiet();

        // frame count change alone keeps the loaded stack
        write_register(CFG_TOTAL_FRAMES, 32'd0);
        queue_mixed(70, '0);
        wait_quiet();

        // highest start the field allows
        write_register(CFG_TOTAL_FRAMES, 32'd1048576);
        write_register(CFG_POOL_BASE, 32'hFFFF_F000);
        queue_mixed(40, 32'hFFFF_F000);
        wait_quiet();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pfa_pkg.sv
rtl/core/pfa_ctrl.sv
rtl/core/pfa_dpath.sv
rtl/core/page_frame_allocator_core.sv
sim/page_frame_allocator_core_test.sv
